@@ sv/fird_pkg.sv @@
// Shared types and constants for the direct-form FIR filter.
// Holds the transaction structs, register indexes, modes and sequencer states.
// No dependencies.
package fird_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int ACC_BITS    = 40;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int TC_BITS     = 7;
  localparam int SH_BITS     = 5;
  localparam int IDX_BITS    = 6;
  localparam int CFG_W       = 7;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TAP_COUNT = 1'b0;
  localparam cfg_idx_t CFG_OUT_SHIFT = 1'b1;

  localparam logic [1:0] MODE_FEED  = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]                    mode;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [IDX_BITS-1:0]           coef_index;
    logic signed [SAMPLE_BITS-1:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_SAT
  } state_t;

  typedef struct packed {
    logic clr;
    logic mul_en;
    logic acc_en;
  } mac_ctl_t;

endpackage

@@ sv/fird_mac.sv @@
// Shared multiply-accumulate unit of the FIR filter.
// Registered product, then 40-bit wrapping accumulator.
// Depends on fird_pkg.
module fird_mac (
  input  logic                                     clk,
  input  fird_pkg::mac_ctl_t                       ctl,
  input  logic signed [fird_pkg::SAMPLE_BITS-1:0]  coef,
  input  logic signed [fird_pkg::SAMPLE_BITS-1:0]  samp,
  output logic signed [fird_pkg::ACC_BITS-1:0]     acc
);
  import fird_pkg::*;

  logic signed [PROD_BITS-1:0] prod_r;
  logic signed [ACC_BITS-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= coef * samp;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + ACC_BITS'(prod_r);
    end
  end

  assign acc = acc_r;

endmodule

@@ sv/fir_filter_direct_form.sv @@
// A sample transaction (mode 0) covers min(tap_count, samples fed since the last history
// clear, MAX_TAPS) taps: one shared multiply-accumulate visits one tap per cycle,
// reading coefficient and history memories, then drains, shifts and saturates.
// Coefficient loads, history clears and unused modes are taken while idle and leave the
// block idle. After reset the block zeroes the coefficient memory and stalls input
// meanwhile; configuration writes are taken at any time. A finished result sits in an
// output register, so the next input transaction is accepted while it waits.
// Depends on fird_pkg and fird_mac.
module fir_filter_direct_form #(
  parameter int MAX_TAPS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  fird_pkg::in_item_t     in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output fird_pkg::out_item_t    out_data,
  input  logic                   cfg_we,
  input  fird_pkg::cfg_idx_t     cfg_index,
  input  logic [fird_pkg::CFG_W-1:0] cfg_wdata
);
  import fird_pkg::*;

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam int NW = (CW > TC_BITS) ? CW : TC_BITS;
  localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;

  state_t state_r, state_nxt;

  logic [TC_BITS-1:0] tap_count_r;
  logic [SH_BITS-1:0] out_shift_r;

  logic [AW-1:0] clr_idx_r;
  logic [AW-1:0] head_r;
  logic [AW-1:0] haddr_r;
  logic [CW-1:0] fill_r;
  logic [CW-1:0] k_r;
  logic [CW-1:0] m_r;
  logic          rd_vld_r;
  logic          mul_vld_r;

  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] taps_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_q_r;
  logic signed [SAMPLE_BITS-1:0] taps_q_r;

  logic signed [ACC_BITS-1:0] acc;
  logic signed [ACC_BITS-1:0] sh_r;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  logic      accept;
  logic      issue;
  logic      drain_done;
  logic      out_load;
  logic      clr_done;
  mac_ctl_t  mac_ctl;

  logic [AW-1:0] head_inc;
  logic [CW-1:0] fill_inc;
  logic [NW-1:0] tc_ext;
  logic [NW-1:0] fill_ext;
  logic [NW-1:0] idx_ext;
  logic          idx_ok;
  logic          taps_we;
  logic [AW-1:0] taps_waddr;
  logic signed [SAMPLE_BITS-1:0] taps_wdata;
  logic          sat_hi;
  logic          sat_lo;
  out_item_t     res;

  // Control outputs of the sequencer
  always_comb begin
    in_stall   = (state_r != S_IDLE);
    accept     = in_valid && (state_r == S_IDLE);
    issue      = (state_r == S_MAC) && (k_r != m_r);
    drain_done = (state_r == S_DRAIN) && !rd_vld_r && !mul_vld_r;
    out_load   = (state_r == S_SAT) && (!out_valid_r || !out_stall);
    clr_done   = (clr_idx_r == AW'(MAX_TAPS - 1));
    mac_ctl.clr    = accept && (in_data.mode == MODE_FEED);
    mac_ctl.mul_en = rd_vld_r;
    mac_ctl.acc_en = mul_vld_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept && (in_data.mode == MODE_FEED)) state_nxt = S_MAC;
      end
      S_MAC: begin
        if (k_r == m_r) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (drain_done) state_nxt = S_SAT;
      end
      S_SAT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TC_BITS'(64);
      out_shift_r <= SH_BITS'(15);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TAP_COUNT: tap_count_r <= cfg_wdata[TC_BITS-1:0];
        CFG_OUT_SHIFT: out_shift_r <= cfg_wdata[SH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    head_inc = (head_r == AW'(MAX_TAPS - 1)) ? '0 : head_r + 1'b1;
    fill_inc = (fill_r == CW'(MAX_TAPS)) ? fill_r : fill_r + 1'b1;
    tc_ext   = NW'(tap_count_r);
    fill_ext = NW'(fill_inc);
    idx_ext  = NW'(in_data.coef_index);
    idx_ok   = (idx_ext < NW'(MAX_TAPS));
  end

  // History ring, fill count, clear index and read pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      fill_r    <= '0;
      clr_idx_r <= '0;
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
    end else begin
      rd_vld_r  <= issue;
      mul_vld_r <= rd_vld_r;
      if (state_r == S_CLEAR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (accept && (in_data.mode == MODE_FEED)) begin
        head_r <= head_inc;
        fill_r <= fill_inc;
      end else if (accept && (in_data.mode == MODE_CLEAR)) begin
        fill_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_data.mode == MODE_FEED)) begin
      haddr_r <= head_inc;
      k_r     <= '0;
      m_r     <= (tc_ext < fill_ext) ? CW'(tc_ext) : CW'(fill_ext);
    end else if (issue) begin
      haddr_r <= (haddr_r == '0) ? AW'(MAX_TAPS - 1) : haddr_r - 1'b1;
      k_r     <= k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_data.mode == MODE_FEED)) begin
      hist_mem[head_inc] <= in_data.sample;
    end
    if (issue) begin
      hist_q_r <= hist_mem[haddr_r];
    end
  end

  always_comb begin
    taps_we    = (state_r == S_CLEAR) || (accept && (in_data.mode == MODE_LOAD) && idx_ok);
    taps_waddr = (state_r == S_CLEAR) ? clr_idx_r : idx_ext[AW-1:0];
    taps_wdata = (state_r == S_CLEAR) ? '0 : in_data.coef_value;
  end

  always_ff @(posedge clk) begin
    if (taps_we) begin
      taps_mem[taps_waddr] <= taps_wdata;
    end
    if (issue) begin
      taps_q_r <= taps_mem[k_r[AW-1:0]];
    end
  end

  fird_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .coef (taps_q_r),
    .samp (hist_q_r),
    .acc  (acc)
  );

  always_ff @(posedge clk) begin
    if (drain_done) begin
      sh_r <= acc >>> out_shift_r;
    end
  end

  always_comb begin
    sat_hi = (sh_r > SAT_HI);
    sat_lo = (sh_r < SAT_LO);
    res.saturated = sat_hi || sat_lo;
    if (sat_hi) begin
      res.filtered = SAT_HI[SAMPLE_BITS-1:0];
    end else if (sat_lo) begin
      res.filtered = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      res.filtered = sh_r[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/fird_chk.sv @@
// Port-level checks for the direct-form FIR filter, bound to the top level.
// Depends on fird_pkg and fir_filter_direct_form.
module fird_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input fird_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input fird_pkg::out_item_t out_data
);
  import fird_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.filtered == 16'sh7fff || out_data.filtered == 16'sh8000))
    else $error("saturation flag without a clipped value");

  a_feed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.mode == MODE_FEED) |=> in_stall)
    else $error("input taken during a sample computation");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open during coefficient clearing");

endmodule

bind fir_filter_direct_form fird_chk u_fird_chk (.*);

@@ bench/fird_checker.sv @@
`timescale 1ns / 1ps
// Checker for the direct-form FIR filter: watches the input, output and register ports,
// keeps its own filter state and compares every output transaction in order.
// Depends on fird_pkg.
module fird_checker #(
  parameter int MAX_TAPS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  fird_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  fird_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  fird_pkg::cfg_idx_t             cfg_index,
  input  logic [fird_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             fail_count,
  output int                             outputs_owed
);
  import fird_pkg::*;

  logic signed [SAMPLE_BITS-1:0] delay_line [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] coefs [MAX_TAPS];
  logic [TC_BITS-1:0]            taps_used;
  logic [SH_BITS-1:0]            shift_amt;
  out_item_t                     filtered_q [$];

  function automatic out_item_t filter_sample(input logic signed [SAMPLE_BITS-1:0] x);
    longint                     acc;
    logic signed [ACC_BITS-1:0] acc40;
    longint                     y;
    int                         n;
    int                         k;
    out_item_t                  r;
    for (k = MAX_TAPS - 1; k > 0; k--) delay_line[k] = delay_line[k-1];
    delay_line[0] = x;
    n = (taps_used > MAX_TAPS) ? MAX_TAPS : int'(taps_used);
    acc = 0;
    for (k = 0; k < n; k++) acc += longint'(coefs[k]) * longint'(delay_line[k]);
    acc40 = acc[ACC_BITS-1:0];
    y = longint'(acc40) >>> shift_amt;
    r.saturated = 1'b0;
    if (y > 32767) begin
      y = 32767;
      r.saturated = 1'b1;
    end else if (y < -32768) begin
      y = -32768;
      r.saturated = 1'b1;
    end
    r.filtered = y[SAMPLE_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      foreach (delay_line[i]) delay_line[i] = '0;
      foreach (coefs[i]) coefs[i] = '0;
      taps_used = 7'd64;
      shift_amt = 5'd15;
      filtered_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TAP_COUNT: taps_used = cfg_wdata[TC_BITS-1:0];
          CFG_OUT_SHIFT: shift_amt = cfg_wdata[SH_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected output transaction, got filtered=%0d saturated=%0b",
                   $time, out_data.filtered, out_data.saturated);
        end else begin
          exp_item = filtered_q.pop_front();
          if (out_data.filtered !== exp_item.filtered ||
              out_data.saturated !== exp_item.saturated) begin
            fail_count++;
            $display("%0t: mismatch, expected filtered=%0d saturated=%0b, got filtered=%0d saturated=%0b",
                     $time, exp_item.filtered, exp_item.saturated,
                     out_data.filtered, out_data.saturated);
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_data.mode)
          MODE_FEED:  filtered_q.push_back(filter_sample(in_data.sample));
          MODE_LOAD:  coefs[in_data.coef_index] = in_data.coef_value;
          MODE_CLEAR: foreach (delay_line[i]) delay_line[i] = '0;
          default: ;
        endcase
      end
    end
    outputs_owed = filtered_q.size();
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the FIR filter bench: clock, reset, register writes, input and output traffic
// and the verdict. Depends on fird_pkg, fir_filter_direct_form and fird_checker.
module tb_top;
  import fird_pkg::*;

  localparam int         MAX_TAPS     = 64;
  localparam int         DRAIN_CYCLES = 80;
  localparam int         CYCLE_LIMIT  = 600000;
  localparam int         PHASES       = 10;
  localparam int         PHASE_ITEMS  = 50;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_we    = 1'b0;
  cfg_idx_t           cfg_index = CFG_TAP_COUNT;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  int fail_count;
  int outputs_owed;
  int cycle_count = 0;
  bit in_idle_on  = 1'b1;
  bit out_idle_on = 1'b1;
  int rx_hold     = 0;

  always #5 clk = ~clk;

  fir_filter_direct_form #(.MAX_TAPS(MAX_TAPS)) dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  fird_checker #(.MAX_TAPS(MAX_TAPS)) u_check (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .outputs_owed
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int draw_gap(input bit on);
    return on ? int'($urandom_range(0, 18)) : 0;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic in_item_t pack_item(input logic [1:0] mode,
                                         input logic signed [SAMPLE_BITS-1:0] sample,
                                         input logic [IDX_BITS-1:0] idx,
                                         input logic signed [SAMPLE_BITS-1:0] coef);
    in_item_t it;
    it.mode       = mode;
    it.sample     = sample;
    it.coef_index = idx;
    it.coef_value = coef;
    return it;
  endfunction

  function automatic in_item_t rand_item(input bit feed_only);
    in_item_t it;
    int       r;
    it.sample     = pick_value();
    it.coef_value = pick_value();
    it.coef_index = $urandom_range(0, 1) ? IDX_BITS'($urandom_range(0, 7))
                                         : IDX_BITS'($urandom);
    r = feed_only ? 0 : int'($urandom_range(0, 99));
    if (r < 70) it.mode = MODE_FEED;
    else if (r < 85) it.mode = MODE_LOAD;
    else if (r < 93) it.mode = MODE_CLEAR;
    else it.mode = MODE_UNUSED;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = draw_gap(in_idle_on);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outputs_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_filter(input logic [TC_BITS-1:0] taps, input logic [SH_BITS-1:0] sh);
    write_reg(CFG_TAP_COUNT, taps);
    write_reg(CFG_OUT_SHIFT, {2'($urandom), sh});
  endtask

  // hold the result side for the drawn gap, then take one transaction
  initial begin : rx_proc
    int w;
    forever begin
      if (rx_hold != 0) begin
        w = rx_hold;
        rx_hold = 0;
      end else begin
        w = draw_gap(out_idle_on);
      end
      @(negedge clk);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stim_proc
    int                 counted;
    in_item_t           it;
    logic [TC_BITS-1:0] taps;
    logic [SH_BITS-1:0] sh;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    send_item(pack_item(MODE_LOAD, 16'sh0000, 6'd0, 16'sh7fff));
    send_item(pack_item(MODE_LOAD, 16'shffff, 6'd1, 16'sh8000));
    send_item(pack_item(MODE_LOAD, 16'sh8000, 6'd63, 16'shffff));
    send_item(pack_item(MODE_LOAD, 16'sh7fff, 6'd2, 16'sh1234));
    send_item(pack_item(MODE_UNUSED, 16'sh7fff, 6'd5, 16'sh7fff));
    send_item(pack_item(MODE_FEED, 16'sh7fff, 6'd63, 16'sh0000));
    send_item(pack_item(MODE_FEED, 16'sh8000, 6'd0, 16'shffff));
    send_item(pack_item(MODE_FEED, 16'shffff, 6'd0, 16'sh0000));
    send_item(pack_item(MODE_FEED, 16'sh0000, 6'd0, 16'sh0000));
    send_item(pack_item(MODE_CLEAR, 16'shffff, 6'd63, 16'shffff));
    send_item(pack_item(MODE_FEED, 16'sh7fff, 6'd0, 16'sh0000));
    wait_idle();
    set_filter(7'd64, 5'd0);
    send_item(pack_item(MODE_FEED, 16'sh7fff, 6'd0, 16'sh0000));
    send_item(pack_item(MODE_FEED, 16'sh8000, 6'd0, 16'sh0000));
    wait_idle();
    set_filter(7'd0, 5'd15);
    send_item(pack_item(MODE_FEED, 16'sh1234, 6'd0, 16'sh0000));
    wait_idle();
    set_filter(7'd127, 5'd31);
    send_item(pack_item(MODE_FEED, 16'sh8000, 6'd0, 16'sh0000));
    send_item(pack_item(MODE_FEED, 16'sh7fff, 6'd0, 16'sh0000));
    wait_idle();
    set_filter(7'd1, 5'd15);
    send_item(pack_item(MODE_FEED, 16'sh8000, 6'd0, 16'sh0000));

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph == 0) taps = 7'd64;
      else if (ph == 1) taps = 7'd1;
      else if ($urandom_range(0, 3) == 0) taps = TC_BITS'($urandom_range(0, 127));
      else taps = TC_BITS'($urandom_range(1, 12));
      sh = $urandom_range(0, 1) ? SH_BITS'($urandom_range(12, 16)) : SH_BITS'($urandom);
      set_filter(taps, sh);
      in_idle_on  = $urandom_range(0, 2) != 0;
      out_idle_on = $urandom_range(0, 2) != 0;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        it = rand_item(1'b0);
        send_item(it);
        if (it.mode != MODE_UNUSED) counted++;
      end
    end

    // back up the output side so the input has to stall
    wait_idle();
    set_filter(7'd4, 5'd15);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    rx_hold     = 300;
    repeat (40) send_item(rand_item(1'b1));

    wait_idle();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
